/* hdl/pli_pkg.sv */
package pli_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int SRCH_STEPS = IDX_W;
   localparam int SLOT_W     = 6;
   localparam int CNT_W      = 7;
   localparam int CMP_W      = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
   localparam int DATA_W     = 32;
   localparam int MAG_W      = DATA_W + 1;
   localparam int PROD_W     = 2 * MAG_W;
   localparam int QUO_W      = 40;
   localparam int DIV_STEP   = 2;
   localparam int DIV_STAGES = QUO_W / DIV_STEP;
   localparam int ADDR_W     = 5;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      REGION_BELOW  = 2'd0,
      REGION_INSIDE = 2'd1,
      REGION_BEYOND = 2'd2
   } region_type;

   typedef enum logic [2:0] {
      CSR_POINT_COUNT = 3'd0,
      CSR_LEFT_USES   = 3'd1,
      CSR_LEFT_FILL   = 3'd2,
      CSR_RIGHT_USES  = 3'd3,
      CSR_RIGHT_FILL  = 3'd4
   } csr_type;

   typedef struct packed {
      kind_type                   kind;
      logic [SLOT_W-1:0]          point_index;
      logic signed [DATA_W-1:0]   point_x;
      logic signed [DATA_W-1:0]   point_y;
      logic signed [DATA_W-1:0]   query_x;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   value;
      region_type                 region;
      logic [SLOT_W-1:0]          segment;
   } rsp_type;

endpackage

/* hdl/piecewise_linear_interpolator.sv */
// Throughput: one request per cycle; busy stays low. Loads write each table copy as they
// pass the pipeline stage that reads it, so requests keep their order.
// Latency is set by the search stages, one table copy per step, and a 20-stage divider.
// Reset clears the valid bits and the registers (point_count 2, all else 0); the table is
// undefined until loaded.
module piecewise_linear_interpolator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  pli_pkg::req_type           req_data,
   output logic                       busy,
   output logic                       rsp_valid,
   output pli_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [pli_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import pli_pkg::*;

   typedef struct packed {
      logic                     valid;
      logic                     load;
      logic                     slot_ok;
      logic [IDX_W-1:0]         addr;
      logic signed [DATA_W-1:0] px;
      logic signed [DATA_W-1:0] py;
      logic [IDX_W-1:0]         lo;
      logic [IDX_W-1:0]         hi;
      logic [IDX_W-1:0]         mid;
      logic [IDX_W-1:0]         fidx;
      logic                     active;
      logic                     pend;
      logic                     found;
      logic                     below;
   } srch_type;

   typedef struct packed {
      logic                     valid;
      region_type               region;
      logic [SLOT_W-1:0]        seg;
      logic signed [DATA_W-1:0] q;
   } locate_type;

   typedef struct packed {
      logic                     valid;
      region_type               region;
      logic [SLOT_W-1:0]        seg;
      logic signed [DATA_W-1:0] base;
      logic                     direct;
      logic [MAG_W-1:0]         dx;
      logic [MAG_W-1:0]         dy;
      logic [MAG_W-1:0]         dq;
   } diff_type;

   typedef struct packed {
      logic                     valid;
      region_type               region;
      logic [SLOT_W-1:0]        seg;
      logic signed [DATA_W-1:0] base;
      logic                     direct;
      logic                     neg;
      logic [MAG_W-1:0]         a;
      logic [MAG_W-1:0]         b;
      logic [MAG_W-1:0]         den;
   } mag_type;

   typedef struct packed {
      logic                     valid;
      region_type               region;
      logic [SLOT_W-1:0]        seg;
      logic signed [DATA_W-1:0] base;
      logic                     direct;
      logic                     neg;
      logic [2*DATA_W-1:0]      pl;
      logic [MAG_W-1:0]         cr;
      logic                     top;
      logic [MAG_W-1:0]         den;
   } prod_type;

   typedef struct packed {
      logic                     valid;
      region_type               region;
      logic [SLOT_W-1:0]        seg;
      logic signed [DATA_W-1:0] base;
      logic                     direct;
      logic                     neg;
      logic                     big;
      logic [MAG_W-1:0]         den;
      logic [MAG_W-1:0]         rem;
      logic [QUO_W-1:0]         low;
      logic [QUO_W-1:0]         quo;
   } div_type;

   function automatic srch_type srch_step(srch_type s, logic signed [DATA_W-1:0] xr);
      srch_type r;
      r = s;
      r.pend = 1'b0;
      if (s.pend) begin
         if (xr < $signed(s.px)) begin
            r.lo = s.mid + 1'b1;
            r.active = r.lo < s.hi;
         end else if (xr > $signed(s.px)) begin
            if (s.mid == s.lo) begin
               r.active = 1'b0;
            end else begin
               r.hi = s.mid - 1'b1;
               r.active = s.lo < r.hi;
            end
         end else begin
            r.found = 1'b1;
            r.fidx = s.mid;
            r.active = 1'b0;
         end
      end
      return r;
   endfunction

   // configuration registers
   logic [CNT_W-1:0]         point_count_ff;
   logic                     left_uses_ff;
   logic signed [DATA_W-1:0] left_fill_ff;
   logic                     right_uses_ff;
   logic signed [DATA_W-1:0] right_fill_ff;
   logic                     csr_write;
   csr_type                  csr_sel;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_sel   = csr_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= CNT_W'(2);
         left_uses_ff   <= 1'b0;
         left_fill_ff   <= '0;
         right_uses_ff  <= 1'b0;
         right_fill_ff  <= '0;
      end else if (csr_write) begin
         case (csr_sel)
            CSR_POINT_COUNT: point_count_ff <= pwdata[CNT_W-1:0];
            CSR_LEFT_USES:   left_uses_ff   <= pwdata[0];
            CSR_LEFT_FILL:   left_fill_ff   <= pwdata;
            CSR_RIGHT_USES:  right_uses_ff  <= pwdata[0];
            CSR_RIGHT_FILL:  right_fill_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_POINT_COUNT: prdata = 32'(point_count_ff);
         CSR_LEFT_USES:   prdata = 32'(left_uses_ff);
         CSR_LEFT_FILL:   prdata = left_fill_ff;
         CSR_RIGHT_USES:  prdata = 32'(right_uses_ff);
         CSR_RIGHT_FILL:  prdata = right_fill_ff;
         default:         prdata = '0;
      endcase
   end

   // index of the last point in use
   logic [CMP_W-1:0] cnt_ext;
   logic [IDX_W-1:0] last_idx;

   always_comb begin
      cnt_ext = CMP_W'(point_count_ff);
      if (cnt_ext == '0) begin
         last_idx = '0;
      end else if (cnt_ext > CMP_W'(MAX_POINTS)) begin
         last_idx = IDX_W'(MAX_POINTS - 1);
      end else begin
         last_idx = IDX_W'(cnt_ext - CMP_W'(1));
      end
   end

   assign busy = 1'b0;

   // entry
   srch_type                    sp_ff [0:SRCH_STEPS+1];
   srch_type                    sn    [0:SRCH_STEPS];
   srch_type                    entry_in;
   logic [IDX_W+SLOT_W-1:0]     slot_wide;
   logic signed [DATA_W-1:0]    rd_x  [0:SRCH_STEPS];
   logic signed [DATA_W-1:0]    x0_ff;

   always_comb begin
      slot_wide        = (IDX_W + SLOT_W)'(req_data.point_index);
      entry_in         = '0;
      entry_in.valid   = start;
      entry_in.load    = req_data.kind == KIND_LOAD;
      entry_in.slot_ok = slot_wide < (IDX_W + SLOT_W)'(MAX_POINTS);
      entry_in.addr    = slot_wide[IDX_W-1:0];
      entry_in.px      = (req_data.kind == KIND_LOAD) ? req_data.point_x : req_data.query_x;
      entry_in.py      = req_data.point_y;
      entry_in.hi      = last_idx;
      entry_in.active  = (req_data.kind == KIND_QUERY) && (last_idx != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff[0].valid <= 1'b0;
      end else begin
         sp_ff[0] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sp_ff[0].valid && sp_ff[0].load && sp_ff[0].slot_ok && sp_ff[0].addr == '0) begin
         x0_ff <= sp_ff[0].px;
      end
   end

   // binary search, one probe per stage, then a final probe at lo
   for (genvar k = 0; k <= SRCH_STEPS; k++) begin : g_srch
      srch_type         nx;
      logic [IDX_W:0]   msum;
      logic [IDX_W-1:0] rd_addr;

      if (k == 0) begin : g_first
         always_comb begin
            sn[k]       = sp_ff[0];
            sn[k].below = $signed(sp_ff[0].px) < x0_ff;
         end
      end else begin : g_rest
         always_comb begin
            sn[k] = srch_step(sp_ff[k], rd_x[k-1]);
         end
      end

      always_comb begin
         nx   = sn[k];
         msum = {1'b0, sn[k].lo} + {1'b0, sn[k].hi};
         if (k < SRCH_STEPS) begin
            nx.mid  = msum[IDX_W:1];
            nx.pend = sn[k].active;
            rd_addr = msum[IDX_W:1];
         end else begin
            rd_addr = sn[k].lo;
         end
      end

      pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_x_ram (
         .clock   (clock),
         .wr_en   (sp_ff[k].valid & sp_ff[k].load & sp_ff[k].slot_ok),
         .wr_addr (sp_ff[k].addr),
         .wr_data (sp_ff[k].px),
         .rd_addr (rd_addr),
         .rd_data (rd_x[k])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            sp_ff[k+1].valid <= 1'b0;
         end else begin
            sp_ff[k+1] <= nx;
         end
      end
   end

   // segment decision and table reads for the segment
   srch_type                 fs;
   logic signed [DATA_W-1:0] fx;
   logic [IDX_W-1:0]         fidx;
   logic                     fneg;
   logic                     fbelow;
   logic                     fright;
   region_type               fregion;
   logic [IDX_W-1:0]         y_addr;
   logic [IDX_W-1:0]         nxt_addr;
   logic                     tbl_wr;
   locate_type               loc_in;
   locate_type               loc_ff;
   logic signed [DATA_W-1:0] x_lo;
   logic signed [DATA_W-1:0] x_hi;
   logic signed [DATA_W-1:0] y_lo;
   logic signed [DATA_W-1:0] y_hi;

   always_comb begin
      fs   = sp_ff[SRCH_STEPS+1];
      fx   = rd_x[SRCH_STEPS];
      fidx = fs.lo;
      fneg = 1'b0;
      if (fs.found) begin
         fidx = fs.fidx;
      end else if (fx > $signed(fs.px)) begin
         if (fs.lo == '0) begin
            fneg = 1'b1;
         end else begin
            fidx = fs.lo - 1'b1;
         end
      end
      fbelow   = fs.below | fneg;
      fright   = !fbelow && (fidx >= last_idx);
      fregion  = fbelow ? REGION_BELOW : (fright ? REGION_BEYOND : REGION_INSIDE);
      y_addr   = fbelow ? '0 : (fright ? last_idx : fidx);
      nxt_addr = fidx + 1'b1;
      tbl_wr   = fs.valid & fs.load & fs.slot_ok;

      loc_in.valid  = fs.valid & ~fs.load;
      loc_in.region = fregion;
      loc_in.seg    = (fregion == REGION_INSIDE) ? SLOT_W'(fidx) : '0;
      loc_in.q      = fs.px;
   end

   pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_xlo_ram (
      .clock(clock), .wr_en(tbl_wr), .wr_addr(fs.addr), .wr_data(fs.px),
      .rd_addr(fidx), .rd_data(x_lo)
   );
   pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_xhi_ram (
      .clock(clock), .wr_en(tbl_wr), .wr_addr(fs.addr), .wr_data(fs.px),
      .rd_addr(nxt_addr), .rd_data(x_hi)
   );
   pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_ylo_ram (
      .clock(clock), .wr_en(tbl_wr), .wr_addr(fs.addr), .wr_data(fs.py),
      .rd_addr(y_addr), .rd_data(y_lo)
   );
   pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_yhi_ram (
      .clock(clock), .wr_en(tbl_wr), .wr_addr(fs.addr), .wr_data(fs.py),
      .rd_addr(nxt_addr), .rd_data(y_hi)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         loc_ff.valid <= 1'b0;
      end else begin
         loc_ff <= loc_in;
      end
   end

   // differences and fill selection
   diff_type dif_in;
   diff_type dif_ff;

   always_comb begin
      dif_in.valid  = loc_ff.valid;
      dif_in.region = loc_ff.region;
      dif_in.seg    = loc_ff.seg;
      dif_in.dx     = {x_hi[DATA_W-1], x_hi} - {x_lo[DATA_W-1], x_lo};
      dif_in.dy     = {y_hi[DATA_W-1], y_hi} - {y_lo[DATA_W-1], y_lo};
      dif_in.dq     = {loc_ff.q[DATA_W-1], loc_ff.q} - {x_lo[DATA_W-1], x_lo};
      case (loc_ff.region)
         REGION_BELOW:  dif_in.base = left_uses_ff ? left_fill_ff : y_lo;
         REGION_BEYOND: dif_in.base = right_uses_ff ? right_fill_ff : y_lo;
         default:       dif_in.base = y_lo;
      endcase
      dif_in.direct = (loc_ff.region != REGION_INSIDE) || (dif_in.dx == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dif_ff.valid <= 1'b0;
      end else begin
         dif_ff <= dif_in;
      end
   end

   // magnitudes and sign
   mag_type mag_in;
   mag_type mag_ff;

   always_comb begin
      mag_in.valid  = dif_ff.valid;
      mag_in.region = dif_ff.region;
      mag_in.seg    = dif_ff.seg;
      mag_in.base   = dif_ff.base;
      mag_in.direct = dif_ff.direct;
      mag_in.neg    = dif_ff.dy[MAG_W-1] ^ dif_ff.dq[MAG_W-1] ^ dif_ff.dx[MAG_W-1];
      mag_in.a      = dif_ff.dy[MAG_W-1] ? -dif_ff.dy : dif_ff.dy;
      mag_in.b      = dif_ff.dq[MAG_W-1] ? -dif_ff.dq : dif_ff.dq;
      mag_in.den    = dif_ff.dx[MAG_W-1] ? -dif_ff.dx : dif_ff.dx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff.valid <= 1'b0;
      end else begin
         mag_ff <= mag_in;
      end
   end

   // partial products
   prod_type pp_in;
   prod_type pp_ff;

   always_comb begin
      pp_in.valid  = mag_ff.valid;
      pp_in.region = mag_ff.region;
      pp_in.seg    = mag_ff.seg;
      pp_in.base   = mag_ff.base;
      pp_in.direct = mag_ff.direct;
      pp_in.neg    = mag_ff.neg;
      pp_in.den    = mag_ff.den;
      pp_in.pl     = mag_ff.a[DATA_W-1:0] * mag_ff.b[DATA_W-1:0];
      pp_in.cr     = (mag_ff.a[DATA_W] ? {1'b0, mag_ff.b[DATA_W-1:0]} : '0)
                   + (mag_ff.b[DATA_W] ? {1'b0, mag_ff.a[DATA_W-1:0]} : '0);
      pp_in.top    = mag_ff.a[DATA_W] & mag_ff.b[DATA_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff.valid <= 1'b0;
      end else begin
         pp_ff <= pp_in;
      end
   end

   // product sum and overflow check ahead of the divider
   div_type             dv_ff [0:DIV_STAGES];
   div_type             dv_in;
   logic [PROD_W-1:0]   prod;

   always_comb begin
      prod = PROD_W'(pp_ff.pl) + (PROD_W'(pp_ff.cr) << DATA_W)
           + (PROD_W'(pp_ff.top) << (2 * DATA_W));
      dv_in.valid  = pp_ff.valid;
      dv_in.region = pp_ff.region;
      dv_in.seg    = pp_ff.seg;
      dv_in.base   = pp_ff.base;
      dv_in.direct = pp_ff.direct;
      dv_in.neg    = pp_ff.neg;
      dv_in.den    = pp_ff.den;
      dv_in.rem    = MAG_W'(prod[PROD_W-1:QUO_W]);
      dv_in.big    = MAG_W'(prod[PROD_W-1:QUO_W]) >= pp_ff.den;
      dv_in.low    = prod[QUO_W-1:0];
      dv_in.quo    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0].valid <= 1'b0;
      end else begin
         dv_ff[0] <= dv_in;
      end
   end

   // restoring divider, DIV_STEP quotient bits per stage
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      div_type        nx;
      logic [MAG_W:0] trial;
      logic           qbit;

      always_comb begin
         nx    = dv_ff[j];
         trial = '0;
         qbit  = 1'b0;
         for (int b = 0; b < DIV_STEP; b++) begin
            trial  = {nx.rem, nx.low[QUO_W-1]};
            nx.low = nx.low << 1;
            qbit   = trial >= {1'b0, nx.den};
            if (qbit) begin
               trial = trial - {1'b0, nx.den};
            end
            nx.rem = trial[MAG_W-1:0];
            nx.quo = {nx.quo[QUO_W-2:0], qbit};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1].valid <= 1'b0;
         end else begin
            dv_ff[j+1] <= nx;
         end
      end
   end

   // apply sign, add base, saturate
   div_type                  dl;
   logic [QUO_W:0]           m;
   logic signed [QUO_W+1:0]  delta;
   logic signed [QUO_W+2:0]  sum;
   logic signed [DATA_W-1:0] sat;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;
   rsp_type                  rsp_data_in;

   always_comb begin
      dl    = dv_ff[DIV_STAGES];
      m     = dl.big ? ((QUO_W + 1)'(1) << QUO_W) : {1'b0, dl.quo};
      delta = dl.neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
      sum   = (QUO_W + 3)'(dl.base) + (QUO_W + 3)'(delta);
      if (sum[QUO_W+2:DATA_W-1] == '0 || sum[QUO_W+2:DATA_W-1] == '1) begin
         sat = sum[DATA_W-1:0];
      end else if (sum[QUO_W+2]) begin
         sat = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(DATA_W-1){1'b1}}};
      end
      rsp_data_in.value   = dl.direct ? dl.base : sat;
      rsp_data_in.region  = dl.region;
      rsp_data_in.segment = dl.seg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dl.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/pli_ram.sv */
module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
